// File: hdl/sgm_pkg.sv
// ----------------------------------------------------------------------------
// sgm_pkg
// Shared constants and types of the Sobel gradient magnitude block.
// ----------------------------------------------------------------------------
package sgm_pkg;

  localparam int unsigned MAX_LINE   = 1024;
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned GRAD_W     = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_LINE_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_COUNT  = 1'b1;

  localparam logic [10:0] LINE_LENGTH_RST = 11'd1024;
  localparam logic [15:0] LINE_COUNT_RST  = 16'd1024;

  typedef logic signed [GRAD_W-1:0] grad_t;

  // line store / window control
  typedef struct packed {
    logic rd;    // read line stores at the new column
    logic step;  // write back, shift window
  } win_ctrl_t;

  // magnitude unit status
  typedef struct packed {
    logic             done;
    logic             last;
    logic [PIX_W-1:0] mag;
  } mag_stat_t;

endpackage

// File: hdl/sgm_window.sv
// ----------------------------------------------------------------------------
// sgm_window
// Line store memory, 3x3 window columns and Sobel X/Y sums.
// ----------------------------------------------------------------------------
module sgm_window #(
  parameter int unsigned MaxLine = sgm_pkg::MAX_LINE
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  sgm_pkg::win_ctrl_t           ctrl_i,
  input  logic [$clog2(MaxLine)-1:0]   addr_i,
  input  logic [sgm_pkg::PIX_W-1:0]    pixel_i,
  output sgm_pkg::grad_t               gx_o,
  output sgm_pkg::grad_t               gy_o
);
  import sgm_pkg::*;

  localparam int unsigned AddrW = $clog2(MaxLine);

  // entry: [15:8] two lines back, [7:0] one line back
  logic [2*PIX_W-1:0] mem [MaxLine];

  logic [2*PIX_W-1:0] rd_q;
  logic [AddrW-1:0]   addr_q;
  logic [PIX_W-1:0]   px_q;
  logic [PIX_W-1:0]   cols_q [6];

  logic [PIX_W-1:0]   w [9];
  logic [9:0]         xp, xn, yp, yn;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd) begin
      rd_q   <= mem[addr_i];
      addr_q <= addr_i;
      px_q   <= pixel_i;
    end
    if (ctrl_i.step) begin
      mem[addr_q] <= {rd_q[PIX_W-1:0], px_q};
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      w[a*3+0] = cols_q[a];
      w[a*3+1] = cols_q[3+a];
    end
    w[2] = rd_q[2*PIX_W-1:PIX_W];
    w[5] = rd_q[PIX_W-1:0];
    w[8] = px_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) cols_q[i] <= '0;
    end else if (ctrl_i.step) begin
      for (int a = 0; a < 3; a++) begin
        cols_q[a]   <= cols_q[3+a];
        cols_q[3+a] <= w[a*3+2];
      end
    end
  end

  assign xp = {2'b0, w[2]} + {1'b0, w[5], 1'b0} + {2'b0, w[8]};
  assign xn = {2'b0, w[0]} + {1'b0, w[3], 1'b0} + {2'b0, w[6]};
  assign yp = {2'b0, w[6]} + {1'b0, w[7], 1'b0} + {2'b0, w[8]};
  assign yn = {2'b0, w[0]} + {1'b0, w[1], 1'b0} + {2'b0, w[2]};

  assign gx_o = $signed({1'b0, xp}) - $signed({1'b0, xn});
  assign gy_o = $signed({1'b0, yp}) - $signed({1'b0, yn});

endmodule

// File: hdl/sgm_mag.sv
// ----------------------------------------------------------------------------
// sgm_mag
// Gradient magnitude: squares on one shared multiplier, then a bit-serial
// floor square root, saturated to 255.
// ----------------------------------------------------------------------------
module sgm_mag (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                last_i,
  input  sgm_pkg::grad_t      gx_i,
  input  sgm_pkg::grad_t      gy_i,
  input  logic                take_i,
  output sgm_pkg::mag_stat_t  stat_o
);
  import sgm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SQX, S_SQY, S_ROOT, S_DONE
  } state_e;

  state_e           state_q;
  logic [9:0]       ax_q, ay_q;
  logic [20:0]      acc_q;
  logic [PIX_W-1:0] res_q;
  logic [2:0]       bit_q;
  logic             last_q;

  logic [GRAD_W-1:0] nx, ny;
  logic [9:0]        ax, ay, mul_a;
  logic [19:0]       prod;
  logic [PIX_W-1:0]  trial;
  logic [15:0]       tsq;

  assign nx    = GRAD_W'(-gx_i);
  assign ny    = GRAD_W'(-gy_i);
  assign ax    = gx_i[GRAD_W-1] ? nx[9:0] : gx_i[9:0];
  assign ay    = gy_i[GRAD_W-1] ? ny[9:0] : gy_i[9:0];
  assign mul_a = (state_q == S_SQX) ? ax_q : ay_q;
  assign prod  = {10'b0, mul_a} * {10'b0, mul_a};
  assign trial = res_q | (PIX_W'(1) << bit_q);
  assign tsq   = {8'b0, trial} * {8'b0, trial};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ax_q    <= '0;
      ay_q    <= '0;
      acc_q   <= '0;
      res_q   <= '0;
      bit_q   <= '0;
      last_q  <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            ax_q    <= ax;
            ay_q    <= ay;
            last_q  <= last_i;
            state_q <= S_SQX;
          end
        end
        S_SQX: begin
          acc_q   <= 21'(prod);
          state_q <= S_SQY;
        end
        S_SQY: begin
          acc_q   <= acc_q + 21'(prod);
          res_q   <= '0;
          bit_q   <= 3'd7;
          state_q <= S_ROOT;
        end
        S_ROOT: begin
          if (acc_q[20:16] != '0) begin
            res_q   <= '1;  // 256 or more saturates
            state_q <= S_DONE;
          end else begin
            if (tsq <= acc_q[15:0]) res_q <= trial;
            bit_q <= bit_q - 3'd1;
            if (bit_q == '0) state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (take_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign stat_o.done = (state_q == S_DONE);
  assign stat_o.last = last_q;
  assign stat_o.mag  = res_q;

endmodule

// File: hdl/sobel_gradient_magnitude.sv
// ----------------------------------------------------------------------------
// sobel_gradient_magnitude
// 3x3 Sobel edge magnitude over a raster pixel stream, interior only.
// ----------------------------------------------------------------------------
//  channel   direction  contents
//  s_axis    in         tdata[7:0] pixel, tuser frame_start
//  m_axis    out        tdata[7:0] magnitude, tlast last_of_frame
//  cfg       in         cfg_idx_i 0 line_length, 1 line_count
//
//  A pixel that gives no result (border) is accepted with a line store
//  read, then written back with a window shift. An interior pixel goes on
//  to the squaring on one shared multiplier and the bit-serial square root
//  (8 steps), cut short when the sum of squares reaches 65536 and the
//  magnitude saturates. A result that finds the output
//  register still full waits until m_axis takes the older one. The output
//  register lets the next pixel in while a result waits on m_axis_tready.
//  Reset clears counters, window and config (1024 x 1024); the line stores
//  hold no reset and are only read where written in the same frame geometry.
// ----------------------------------------------------------------------------
module sobel_gradient_magnitude #(
  parameter int unsigned MaxLine = sgm_pkg::MAX_LINE
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // pixel in
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,   // [7:0] pixel
  input  logic                              s_axis_tuser,   // [0] frame_start
  // magnitude out
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [7:0]                        m_axis_tdata,   // [7:0] magnitude
  output logic                              m_axis_tlast,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [sgm_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [sgm_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import sgm_pkg::*;

  localparam int unsigned ColW = $clog2(MaxLine);

  typedef enum logic [1:0] {
    ST_IDLE, ST_WIN, ST_MAG
  } state_e;

  state_e            state_q;
  logic [10:0]       len_q;
  logic [15:0]       cnt_q;
  logic [ColW-1:0]   col_q;
  logic [15:0]       row_q;
  logic              produce_q, last_q;
  logic              out_valid_q, out_last_q;
  logic [PIX_W-1:0]  out_data_q;

  logic              accept;
  logic [15:0]       len_eff, cnt_eff;
  logic [ColW-1:0]   pos_col, col_d;
  logic [15:0]       pos_row, row_d, col_ext;
  logic              produce_d, last_d;
  logic              out_free, load_out;

  win_ctrl_t         win_ctrl;
  grad_t             gx, gy;
  mag_stat_t         mag_stat;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // effective geometry: length clamped to [3, MaxLine], count to at least 3
  always_comb begin
    len_eff = 16'(len_q);
    if (len_eff < 16'd3)               len_eff = 16'd3;
    else if (len_eff > 16'(MaxLine))   len_eff = 16'(MaxLine);
    cnt_eff = (cnt_q < 16'd3) ? 16'd3 : cnt_q;
  end

  // position of the incoming pixel and counters after it
  always_comb begin
    pos_col   = s_axis_tuser ? '0 : col_q;
    pos_row   = s_axis_tuser ? '0 : row_q;
    col_ext   = 16'(pos_col);
    produce_d = (pos_row >= 16'd2) && (col_ext >= 16'd2) &&
                (pos_row < cnt_eff) && (col_ext < len_eff);
    last_d    = (pos_row == cnt_eff - 16'd1) && (col_ext == len_eff - 16'd1);
    if (col_ext + 16'd1 >= len_eff) begin
      col_d = '0;
      row_d = (17'(pos_row) + 17'd1 >= 17'(cnt_eff)) ? '0 : pos_row + 16'd1;
    end else begin
      col_d = pos_col + ColW'(1);
      row_d = pos_row;
    end
  end

  assign win_ctrl.rd   = accept;
  assign win_ctrl.step = (state_q == ST_WIN);

  sgm_window #(
    .MaxLine (MaxLine)
  ) u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (win_ctrl),
    .addr_i  (pos_col),
    .pixel_i (s_axis_tdata),
    .gx_o    (gx),
    .gy_o    (gy)
  );

  sgm_mag u_mag (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (win_ctrl.step && produce_q),
    .last_i  (last_q),
    .gx_i    (gx),
    .gy_i    (gy),
    .take_i  (load_out),
    .stat_o  (mag_stat)
  );

  assign out_free = !out_valid_q || m_axis_tready;
  assign load_out = (state_q == ST_MAG) && mag_stat.done && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= LINE_LENGTH_RST;
      cnt_q       <= LINE_COUNT_RST;
      col_q       <= '0;
      row_q       <= '0;
      produce_q   <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_LINE_LENGTH: len_q <= cfg_data_i[10:0];
          CFG_LINE_COUNT:  cnt_q <= cfg_data_i;
        endcase
      end

      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            col_q     <= col_d;
            row_q     <= row_d;
            produce_q <= produce_d;
            last_q    <= last_d;
            state_q   <= ST_WIN;
          end
        end
        ST_WIN: state_q <= produce_q ? ST_MAG : ST_IDLE;
        ST_MAG: if (load_out) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase

      if (load_out)           out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_data_q <= mag_stat.mag;
      out_last_q <= mag_stat.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule
